// ----- sv/bpra_pkg.sv -----
// ----------------------------------------------------------------------------
// Page run allocator package
// Command, status and beat types shared by the allocator modules.
// ----------------------------------------------------------------------------
package bpra_pkg;

  localparam int CmdW   = 2;
  localparam int PageW  = 14;
  localparam int CountW = 15;
  localparam int StatW  = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_NULL  = 2'd1,
    ST_NOFIT = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [PageW-1:0]  start_page;
    logic [CountW-1:0] page_count;
  } in_beat_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [PageW-1:0] granted_page;
  } out_beat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RUN_RD,
    S_RUN_WAIT,
    S_RUN_WR,
    S_DONE
  } state_t;

endpackage

// ----- sv/bpra_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, registered read data.
// ----------------------------------------------------------------------------
module bpra_ram #(
  parameter int Width = 64,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/bitmap_page_run_allocator_top.sv -----
// ----------------------------------------------------------------------------
// Bitmap page run allocator
// First-fit contiguous page allocator over a bitmap held in one RAM.
// ----------------------------------------------------------------------------
// From the accepting edge to the out_valid beat: a rejected command goes to
// S_DONE; free/reserve pass S_RUN_RD, S_RUN_WAIT, S_RUN_WR per bitmap word
// touched; allocate passes S_SCAN_RD, S_SCAN_CHK per word scanned (all bits
// of a word are tested at once), then the run states per word marked. One
// command at a time: busy drops in the beat's cycle. After reset busy stays high
// while the bitmap RAM is cleared one word per cycle. The receiver cannot stall.
module bitmap_page_run_allocator_top #(
  parameter int NUM_PAGES = 16384,
  parameter int WORD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  bpra_pkg::in_beat_t in_beat,
  output logic               out_valid,
  output bpra_pkg::out_beat_t out_beat
);

  localparam int Words = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW    = (Words > 1) ? $clog2(Words) : 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam int TW    = BW + 1;
  localparam int PW    = (($clog2(NUM_PAGES) > bpra_pkg::CountW) ?
                          $clog2(NUM_PAGES) : bpra_pkg::CountW) + 2;

  bpra_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]  addr_r, addr_nxt;
  logic [PW-1:0]  run_r, run_nxt;
  logic [PW-1:0]  first_r, first_nxt;
  logic [PW-1:0]  last_r, last_nxt;
  logic [PW-1:0]  count_r, count_nxt;
  logic           setv_r, setv_nxt;
  logic [1:0]     stat_r, stat_nxt;
  logic [PW-1:0]  gnt_r, gnt_nxt;
  logic           ov_r, ov_nxt;

  logic                 we;
  logic [AW-1:0]        ram_addr;
  logic [WORD_BITS-1:0] wdata, rdata, mask;

  bpra_ram #(.Width(WORD_BITS), .Depth(Words)) u_ram (
    .clk(clk), .we(we), .addr(ram_addr), .wdata(wdata), .rdata(rdata)
  );

  // Bit mask of the run [first_r, last_r] within the current word.
  always_comb begin
    logic [PW-1:0] pg;
    mask = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      pg = PW'({addr_r, BW'(0)}) + PW'(b);
      mask[b] = (pg >= first_r) && (pg <= last_r);
    end
  end

  // cnt_ge[d] is set when the requested run is at least d pages long.
  logic [WORD_BITS:1] cnt_ge;
  always_comb begin
    for (int d = 1; d <= WORD_BITS; d++) begin
      cnt_ge[d] = (count_r >= PW'(d));
    end
  end

  // Run scan over one word. A run ends at bit b when the bits of the word
  // inside the run are free and the free run carried in from lower words
  // makes up the rest. The lowest such bit is the first fit.
  logic [PW-1:0]        scan_run;
  logic                 scan_hit;
  logic [PW-1:0]        scan_found;
  logic [WORD_BITS-1:0] hit_vec;
  always_comb begin
    logic [WORD_BITS-1:0] win;
    logic [BW-1:0]        hit_pos;
    logic [TW-1:0]        tail;
    hit_vec = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      win = '0;
      for (int j = 0; j <= b; j++) begin
        win[j] = cnt_ge[b - j + 1];
      end
      hit_vec[b] = ((rdata & win) == '0) &&
                   (run_r + PW'(b + 1) >= count_r) &&
                   (PW'({addr_r, BW'(0)}) + PW'(b) < PW'(NUM_PAGES));
    end
    scan_hit = |hit_vec;
    hit_pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (hit_vec[b]) begin
        hit_pos = BW'(b);
      end
    end
    scan_found = PW'({addr_r, hit_pos}) + 1'b1 - count_r;
    // Free bits above the highest used bit carry into the next word.
    tail = TW'(WORD_BITS);
    for (int b = 0; b < WORD_BITS; b++) begin
      if (rdata[b]) begin
        tail = TW'(WORD_BITS - 1 - b);
      end
    end
    scan_run = (tail == TW'(WORD_BITS)) ? (run_r + PW'(WORD_BITS)) : PW'(tail);
  end

  // Next state.
  always_comb begin
    logic [PW-1:0] endp;
    state_nxt = state_r;
    addr_nxt  = addr_r;
    run_nxt   = run_r;
    first_nxt = first_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    setv_nxt  = setv_r;
    stat_nxt  = stat_r;
    gnt_nxt   = gnt_r;
    ov_nxt    = 1'b0;
    endp      = PW'(in_beat.start_page) + PW'(in_beat.page_count);
    case (state_r)
      bpra_pkg::S_CLEAR: begin
        addr_nxt = addr_r + 1'b1;
        if (addr_r == AW'(Words - 1)) begin
          state_nxt = bpra_pkg::S_IDLE;
        end
      end
      bpra_pkg::S_IDLE: begin
        if (start) begin
          count_nxt = PW'(in_beat.page_count);
          stat_nxt  = bpra_pkg::ST_OK;
          gnt_nxt   = '0;
          state_nxt = bpra_pkg::S_DONE;
          if (in_beat.command == bpra_pkg::CMD_ALLOC) begin
            if (in_beat.page_count == '0) begin
              stat_nxt = bpra_pkg::ST_NULL;
            end else if (PW'(in_beat.page_count) > PW'(NUM_PAGES)) begin
              stat_nxt = bpra_pkg::ST_RANGE;
            end else begin
              addr_nxt  = '0;
              run_nxt   = '0;
              setv_nxt  = 1'b1;
              state_nxt = bpra_pkg::S_SCAN_RD;
            end
          end else if (in_beat.command == bpra_pkg::CMD_FREE ||
                       in_beat.command == bpra_pkg::CMD_RESERVE) begin
            if (in_beat.page_count == '0 ||
                (in_beat.command == bpra_pkg::CMD_FREE && in_beat.start_page == '0)) begin
              stat_nxt = bpra_pkg::ST_NULL;
            end else if (endp > PW'(NUM_PAGES)) begin
              stat_nxt = bpra_pkg::ST_RANGE;
            end else begin
              first_nxt = PW'(in_beat.start_page);
              last_nxt  = endp - 1'b1;
              addr_nxt  = AW'(PW'(in_beat.start_page) >> BW);
              setv_nxt  = (in_beat.command == bpra_pkg::CMD_RESERVE);
              state_nxt = bpra_pkg::S_RUN_RD;
            end
          end else begin
            stat_nxt = bpra_pkg::ST_RANGE;
          end
        end
      end
      bpra_pkg::S_SCAN_RD: begin
        state_nxt = bpra_pkg::S_SCAN_CHK;
      end
      bpra_pkg::S_SCAN_CHK: begin
        run_nxt = scan_run;
        if (scan_hit) begin
          first_nxt = scan_found;
          last_nxt  = scan_found + count_r - 1'b1;
          gnt_nxt   = scan_found;
          addr_nxt  = AW'(scan_found >> BW);
          state_nxt = bpra_pkg::S_RUN_RD;
        end else if (addr_r == AW'(Words - 1)) begin
          stat_nxt  = bpra_pkg::ST_NOFIT;
          state_nxt = bpra_pkg::S_DONE;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = bpra_pkg::S_SCAN_RD;
        end
      end
      bpra_pkg::S_RUN_RD: begin
        state_nxt = bpra_pkg::S_RUN_WAIT;
      end
      bpra_pkg::S_RUN_WAIT: begin
        state_nxt = bpra_pkg::S_RUN_WR;
      end
      bpra_pkg::S_RUN_WR: begin
        if (PW'({addr_r, BW'(0)}) + PW'(WORD_BITS) > last_r) begin
          state_nxt = bpra_pkg::S_DONE;
        end else begin
          addr_nxt  = addr_r + 1'b1;
          state_nxt = bpra_pkg::S_RUN_RD;
        end
      end
      bpra_pkg::S_DONE: begin
        ov_nxt    = 1'b1;
        state_nxt = bpra_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bpra_pkg::S_IDLE;
      end
    endcase
  end

  // RAM port control.
  always_comb begin
    we       = 1'b0;
    ram_addr = addr_r;
    wdata    = '0;
    case (state_r)
      bpra_pkg::S_CLEAR: begin
        we = 1'b1;
      end
      bpra_pkg::S_RUN_WR: begin
        we    = 1'b1;
        wdata = setv_r ? (rdata | mask) : (rdata & ~mask);
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bpra_pkg::S_CLEAR;
      addr_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      addr_r  <= addr_nxt;
      ov_r    <= ov_nxt;
    end
    run_r   <= run_nxt;
    first_r <= first_nxt;
    last_r  <= last_nxt;
    count_r <= count_nxt;
    setv_r  <= setv_nxt;
    stat_r  <= stat_nxt;
    gnt_r   <= gnt_nxt;
  end

  assign busy                  = (state_r != bpra_pkg::S_IDLE);
  assign out_valid             = ov_r;
  assign out_beat.status       = stat_r;
  assign out_beat.granted_page = gnt_r[bpra_pkg::PageW-1:0];

endmodule

// ----- tb/sv/bitmap_page_run_allocator_top_tb.sv -----
// ----------------------------------------------------------------------------
// Page run allocator testbench
// Drives allocate, free, reserve and unused commands via the start/busy port;
// checks each beat against a fixed beat or a bit-level first-fit bitmap model.
// ----------------------------------------------------------------------------
module bitmap_page_run_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPAGES = 16384;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  bpra_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  bpra_pkg::out_beat_t out_beat;

  bitmap_page_run_allocator_top uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_beat(in_beat), .out_valid(out_valid), .out_beat(out_beat)
  );

  always #5 clk = ~clk;

  typedef struct packed {
    bpra_pkg::in_beat_t  cmd;
    logic                fixed;
    bpra_pkg::out_beat_t beat;
  } row_t;

  bit                  used_copy [NPAGES];
  bpra_pkg::out_beat_t pending_q[$];
  int                  mismatches = 0;

  // Applies one command to the bitmap copy and returns the expected beat.
  function automatic bpra_pkg::out_beat_t run_page_cmd(bpra_pkg::in_beat_t c);
    bpra_pkg::out_beat_t r;
    int                  run, found, cnt, st;
    r = '0;
    cnt = c.page_count;
    st = c.start_page;
    r.status = bpra_pkg::ST_OK;
    case (bpra_pkg::cmd_t'(c.command))
      bpra_pkg::CMD_ALLOC: begin
        if (cnt == 0) r.status = bpra_pkg::ST_NULL;
        else if (cnt > NPAGES) r.status = bpra_pkg::ST_RANGE;
        else begin
          run = 0;
          found = -1;
          for (int p = 0; p < NPAGES; p++) begin
            if (used_copy[p]) run = 0;
            else begin
              run++;
              if (run == cnt) begin
                found = p + 1 - cnt;
                break;
              end
            end
          end
          if (found < 0) r.status = bpra_pkg::ST_NOFIT;
          else begin
            for (int i = 0; i < cnt; i++) used_copy[found + i] = 1'b1;
            r.granted_page = found[bpra_pkg::PageW-1:0];
          end
        end
      end
      bpra_pkg::CMD_FREE, bpra_pkg::CMD_RESERVE: begin
        if (cnt == 0 || (c.command == bpra_pkg::CMD_FREE && st == 0))
          r.status = bpra_pkg::ST_NULL;
        else if (st + cnt > NPAGES) r.status = bpra_pkg::ST_RANGE;
        else begin
          for (int i = 0; i < cnt; i++)
            used_copy[st + i] = (c.command == bpra_pkg::CMD_RESERVE);
        end
      end
      default: r.status = bpra_pkg::ST_RANGE;
    endcase
    return r;
  endfunction

  // Returns in the time step of the accepting edge; start is left high.
  task automatic send_cmd(bpra_pkg::in_beat_t c, bit fixed,
                          bpra_pkg::out_beat_t fixed_beat, bit idle_ok);
    bpra_pkg::out_beat_t pred;
    if (idle_ok && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    start <= 1'b1;
    in_beat <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = run_page_cmd(c);
    pending_q.push_back(fixed ? fixed_beat : pred);
  endtask

  // Result beats land one per command; the receiver cannot stall.
  always @(posedge clk) begin
    bpra_pkg::out_beat_t e;
    if (rst_n && out_valid) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result beat %p", out_beat);
      end else begin
        e = pending_q.pop_front();
        if (out_beat.status !== e.status ||
            out_beat.granted_page !== e.granted_page) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: expected status %0d page %0d, got status %0d page %0d",
                     e.status, e.granted_page,
                     out_beat.status, out_beat.granted_page);
        end
      end
    end
  end

  function automatic bpra_pkg::in_beat_t mk(bpra_pkg::cmd_t c, int sp, int pc);
    bpra_pkg::in_beat_t b;
    b.command = c;
    b.start_page = sp[bpra_pkg::PageW-1:0];
    b.page_count = pc[bpra_pkg::CountW-1:0];
    return b;
  endfunction

  function automatic bpra_pkg::out_beat_t ob(bpra_pkg::status_t s, int g);
    bpra_pkg::out_beat_t b;
    b.status = s;
    b.granted_page = g[bpra_pkg::PageW-1:0];
    return b;
  endfunction

  initial begin
    row_t               rows[$];
    bpra_pkg::in_beat_t c;
    int                 pick, cnt, sp;

    for (int i = 0; i < NPAGES; i++) used_copy[i] = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 0, 1), 1'b1, ob(bpra_pkg::ST_OK, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 0, 0), 1'b1, ob(bpra_pkg::ST_NULL, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 0, 1), 1'b1, ob(bpra_pkg::ST_NULL, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 5, 0), 1'b1, ob(bpra_pkg::ST_NULL, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_RESERVE, 3, 0), 1'b1, ob(bpra_pkg::ST_NULL, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 0, 16385), 1'b1, ob(bpra_pkg::ST_RANGE, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 16383, 32767), 1'b1,
                     ob(bpra_pkg::ST_RANGE, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 16383, 2), 1'b1, ob(bpra_pkg::ST_RANGE, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_RESERVE, 16383, 1), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_UNUSED, 16383, 32767), 1'b1,
                     ob(bpra_pkg::ST_RANGE, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_UNUSED, 0, 0), 1'b1, ob(bpra_pkg::ST_RANGE, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 0, 16384), 1'b1, ob(bpra_pkg::ST_NOFIT, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 0, 5), 1'b1, ob(bpra_pkg::ST_OK, 1)});
    rows.push_back('{mk(bpra_pkg::CMD_RESERVE, 0, 3), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 2, 2), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 0, 2), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 1, 16383), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_RESERVE, 0, 16384), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 0, 1), 1'b1, ob(bpra_pkg::ST_NOFIT, 0)});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 8191, 1), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 0, 1), 1'b1, ob(bpra_pkg::ST_OK, 8191)});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 10922, 5461), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_ALLOC, 5461, 5461), 1'b1,
                     ob(bpra_pkg::ST_OK, 10922)});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 1, 16383), 1'b0, '0});
    rows.push_back('{mk(bpra_pkg::CMD_FREE, 0, 16384), 1'b1, ob(bpra_pkg::ST_NULL, 0)});

    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].fixed, rows[i].beat, 1'b1);
    start <= 1'b0;

    // Let the block drain completely before the random traffic.
    while (pending_q.size() != 0) @(posedge clk);

    for (int n = 0; n < 700; n++) begin
      pick = $urandom_range(0, 99);
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 32767)
                                         : $urandom_range(0, 40);
      if (pick < 35) c = mk(bpra_pkg::CMD_ALLOC, $urandom_range(0, 16383), cnt);
      else if (pick < 70) c = mk(bpra_pkg::CMD_FREE, $urandom_range(0, 16383), cnt);
      else if (pick < 97) c = mk(bpra_pkg::CMD_RESERVE, $urandom_range(0, 16383), cnt);
      else c = mk(bpra_pkg::CMD_UNUSED, $urandom_range(0, 16383), cnt);
      if (n < 350 && pick < 70 && pick >= 35) begin
        sp = $urandom_range(0, 1023);
        c.start_page = sp[bpra_pkg::PageW-1:0];
      end
      if (n == 350) begin
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end
      send_cmd(c, 1'b0, '0, n < 600);
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
